@@ sv/direct_mapped_aging_cache_unit_macros.svh @@
// Assertion macros for the direct-mapped aging cache unit.
`ifndef DIRECT_MAPPED_AGING_CACHE_UNIT_MACROS_SVH
`define DIRECT_MAPPED_AGING_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DMAC_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dmac assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DMAC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dmac assertion failed");

`endif

@@ sv/dmac_pkg.sv @@
// Shared codes and types of the direct-mapped aging cache unit.
package dmac_pkg;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 16;
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 11;
  localparam int LIVE_MAX = 2047;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd4;

  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_MARKER = 2'd1;
  localparam logic [1:0] KIND_LIVE   = 2'd2;

  // Per-slot tag: kind plus referenced bit.
  typedef struct packed {
    logic [1:0] kind;
    logic       refd;
  } slot_ent_t;

  // Decision of the slot update unit for one slot.
  typedef struct packed {
    logic      we;
    slot_ent_t ent;
    logic      handle_we;
    logic      hit;
    logic      marker;
  } slot_upd_t;

endpackage

@@ sv/dmac_slot_store.sv @@
// Slot tag memory and slot handle memory, one read and one write port each.
module dmac_slot_store #(
  parameter int SLOTS = 1024,
  parameter int AW    = 10,
  parameter int HW    = 16
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  output dmac_pkg::slot_ent_t rd_ent,
  output logic [HW-1:0]       rd_handle,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  dmac_pkg::slot_ent_t wr_ent,
  input  logic                hwr_en,
  input  logic [HW-1:0]       hwr_data
);

  dmac_pkg::slot_ent_t tag_mem [SLOTS];
  logic [HW-1:0]       handle_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_ent;
    end
    rd_ent <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (hwr_en) begin
      handle_mem[wr_addr] <= hwr_data;
    end
    rd_handle <= handle_mem[rd_addr];
  end

endmodule

@@ sv/dmac_update.sv @@
// Shared slot update unit: new slot tag, hit flags and live count step.
module dmac_update #(
  parameter int CW = 11
) (
  input  logic [dmac_pkg::CMD_W-1:0] cmd,
  input  logic                       is_null,
  input  dmac_pkg::slot_ent_t        ent,
  input  logic [CW-1:0]              count,
  output dmac_pkg::slot_upd_t        upd,
  output logic [CW-1:0]              count_next
);

  logic is_live;
  logic is_marker;
  logic inc;
  logic dec;
  logic [CW-1:0] after_dec;

  assign is_live   = (ent.kind == dmac_pkg::KIND_LIVE);
  assign is_marker = (ent.kind == dmac_pkg::KIND_MARKER);

  always_comb begin
    upd = '0;
    inc = 1'b0;
    dec = 1'b0;
    case (cmd)
      dmac_pkg::CMD_ADD: begin
        upd.we        = 1'b1;
        upd.ent.kind  = is_null ? dmac_pkg::KIND_MARKER : dmac_pkg::KIND_LIVE;
        upd.handle_we = !is_null;
        dec           = is_live;
        inc           = !is_null;
      end
      dmac_pkg::CMD_REMOVE: begin
        upd.we       = 1'b1;
        upd.ent.kind = dmac_pkg::KIND_EMPTY;
        dec          = is_live;
      end
      dmac_pkg::CMD_FIND: begin
        if (is_live) begin
          upd.we       = 1'b1;
          upd.ent.kind = dmac_pkg::KIND_LIVE;
          upd.ent.refd = 1'b1;
          upd.hit      = 1'b1;
        end else if (is_marker) begin
          upd.hit    = 1'b1;
          upd.marker = 1'b1;
        end
      end
      dmac_pkg::CMD_SWEEP: begin
        // Second chance: drop the referenced bit, or evict if already clear.
        if (is_live) begin
          upd.we       = 1'b1;
          upd.ent.kind = ent.refd ? dmac_pkg::KIND_LIVE : dmac_pkg::KIND_EMPTY;
          dec          = !ent.refd;
        end
      end
      default: begin
      end
    endcase
  end

  assign after_dec  = (dec && count != '0) ? count - CW'(1) : count;
  assign count_next = inc ? after_dec + CW'(1) : after_dec;

endmodule

@@ sv/direct_mapped_aging_cache_unit.sv @@
// Top level of the direct-mapped aging cache unit: sequencer and result register.
//
//  channel | handshake          | fields
//  --------+--------------------+--------------------------------------------------
//  input   | in_valid/in_ready  | command, slot_index, entry_handle, handle_is_null
//  output  | out_valid/out_ready| hit, marker_hit, found_handle, live_count
//
// Add, remove, find and unknown commands reach their result by reading the slot, updating
// it (add, remove and find only) and loading the result register.
// Sweep and clear all walk the whole table: the walk visits one slot a cycle through
// the single read and write port of the slot tag memory.
// After reset a clearing pass writes every slot empty; in_ready stays low meanwhile.
// in_ready is high only while the sequencer idles; a finished result waits in the
// output register, and a new transaction may be accepted while it waits.
module direct_mapped_aging_cache_unit #(
  parameter int SLOTS       = 1024,
  parameter int HANDLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dmac_pkg::CMD_W-1:0]   command,
  input  logic [dmac_pkg::IDX_W-1:0]   slot_index,
  input  logic [dmac_pkg::FIELD_W-1:0] entry_handle,
  input  logic                         handle_is_null,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic                         marker_hit,
  output logic [dmac_pkg::FIELD_W-1:0] found_handle,
  output logic [dmac_pkg::COUNT_W-1:0] live_count
);

`include "direct_mapped_aging_cache_unit_macros.svh"

  // Address, stored handle and counter widths.
  localparam int AW = $clog2(SLOTS);
  localparam int HW = (HANDLE_BITS < dmac_pkg::FIELD_W) ? HANDLE_BITS : dmac_pkg::FIELD_W;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int WW = (CW > dmac_pkg::COUNT_W) ? CW : dmac_pkg::COUNT_W;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                   state;
  logic [AW-1:0]                scan;
  logic                         clr_cmd;
  logic [CW-1:0]                count;
  logic                         p_valid;
  logic [AW-1:0]                p_addr;
  logic [dmac_pkg::CMD_W-1:0]   cmd;
  logic                         is_null;
  logic [HW-1:0]                handle;
  logic                         res_hit;
  logic                         res_marker;
  logic [dmac_pkg::FIELD_W-1:0] res_handle;

  logic                         accept;
  logic                         res_load;
  logic                         in_range;
  logic [AW-1:0]                rd_addr;
  dmac_pkg::slot_ent_t          rd_ent;
  logic [HW-1:0]                rd_handle;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  dmac_pkg::slot_ent_t          wr_ent;
  logic                         hwr_en;
  dmac_pkg::slot_upd_t          upd;
  logic [CW-1:0]                count_next;
  logic [WW-1:0]                count_wide;
  logic [dmac_pkg::COUNT_W-1:0] count_sat;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = {16'b0, slot_index} < 32'(SLOTS);

  // Load the result register once it is empty or being emptied.
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);

  // Read the addressed slot on acceptance; walk the table during a sweep.
  assign rd_addr = (state == S_SWEEP) ? scan : slot_index[AW-1:0];

  // The clearing pass owns the write port; otherwise write back the update.
  assign wr_en   = (state == S_CLEAR) || (p_valid && upd.we);
  assign wr_addr = (state == S_CLEAR) ? scan : p_addr;
  assign wr_ent  = (state == S_CLEAR) ? dmac_pkg::slot_ent_t'('0) : upd.ent;
  assign hwr_en  = p_valid && upd.handle_we && (state != S_CLEAR);

  dmac_slot_store #(
    .SLOTS(SLOTS),
    .AW   (AW),
    .HW   (HW)
  ) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_ent   (rd_ent),
    .rd_handle(rd_handle),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_ent   (wr_ent),
    .hwr_en   (hwr_en),
    .hwr_data (handle)
  );

  dmac_update #(
    .CW(CW)
  ) u_update (
    .cmd       (cmd),
    .is_null   (is_null),
    .ent       (rd_ent),
    .count     (count),
    .upd       (upd),
    .count_next(count_next)
  );

  // Saturate the reported count to the port range.
  assign count_wide = WW'(count);
  assign count_sat  = (count_wide > WW'(dmac_pkg::LIVE_MAX)) ?
                      dmac_pkg::COUNT_W'(dmac_pkg::LIVE_MAX) :
                      count_wide[dmac_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan      <= '0;
      clr_cmd   <= 1'b0;
      count     <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise valid with a new result, or drop it once the waiting one is taken.
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // Retire the pending slot access: count follows the write-back.
      if (p_valid) begin
        count <= count_next;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd        <= command;
            is_null    <= handle_is_null;
            handle     <= entry_handle[HW-1:0];
            p_addr     <= slot_index[AW-1:0];
            res_hit    <= 1'b0;
            res_marker <= 1'b0;
            res_handle <= '0;
            scan       <= '0;
            case (command)
              dmac_pkg::CMD_CLEAR: begin
                count   <= '0;
                clr_cmd <= 1'b1;
                p_valid <= 1'b0;
                state   <= S_CLEAR;
              end
              dmac_pkg::CMD_SWEEP: begin
                p_valid <= 1'b0;
                state   <= S_SWEEP;
              end
              default: begin
                // Unknown commands and out-of-range slots leave no pending access.
                p_valid <= in_range && (command == dmac_pkg::CMD_ADD ||
                                        command == dmac_pkg::CMD_REMOVE ||
                                        command == dmac_pkg::CMD_FIND);
                state   <= S_DRAIN;
              end
            endcase
          end
        end
        S_CLEAR: begin
          scan <= scan + AW'(1);
          if (scan == LAST) begin
            state   <= clr_cmd ? S_DONE : S_IDLE;
            clr_cmd <= 1'b0;
          end
        end
        S_SWEEP: begin
          // Read slot scan now; it is written back next cycle.
          p_valid <= 1'b1;
          p_addr  <= scan;
          scan    <= scan + AW'(1);
          if (scan == LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          p_valid    <= 1'b0;
          res_hit    <= p_valid && upd.hit;
          res_marker <= p_valid && upd.marker;
          res_handle <= (p_valid && upd.hit && !upd.marker) ?
                        dmac_pkg::FIELD_W'(rd_handle) : '0;
          state      <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload; loaded only when the result register takes a new transaction.
  always_ff @(posedge clk) begin
    if (res_load) begin
      hit          <= res_hit;
      marker_hit   <= res_marker;
      found_handle <= res_handle;
      live_count   <= count_sat;
    end
  end

  `DMAC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
  `DMAC_ASSERT_IMPL(a_clear_count_zero, state == S_CLEAR, count == '0)
  `DMAC_ASSERT_IMPL(a_result_from_done, $rose(out_valid), $past(state) == S_DONE)
  `DMAC_ASSERT_IMPL(a_marker_is_hit, out_valid && marker_hit, hit && found_handle == '0)

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench of the direct-mapped aging cache unit, checked against a shadow slot table.
module testbench;

  localparam int SLOTS       = 1024;
  localparam int HANDLE_BITS = 16;

  // Commands 5 to 7 have no meaning; the block must leave the table alone.
  localparam logic [dmac_pkg::CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [dmac_pkg::CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [dmac_pkg::CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

  localparam logic [dmac_pkg::FIELD_W-1:0] HANDLE_MASK =
    {dmac_pkg::FIELD_W{1'b1}} >> (dmac_pkg::FIELD_W - HANDLE_BITS);

  // Last slot in range and first slot past the table.
  localparam logic [dmac_pkg::IDX_W-1:0] TOP_SLOT  = dmac_pkg::IDX_W'(SLOTS - 1);
  localparam logic [dmac_pkg::IDX_W-1:0] OUT_SLOT  = dmac_pkg::IDX_W'(SLOTS);

  // Window of transactions during which neither side idles.
  localparam int QUIET_FROM = 500;
  localparam int QUIET_TO   = 800;

  // Walks (sweep, clear all) visit every slot; cap them.
  localparam int WALK_BUDGET  = 80;
  localparam int RANDOM_ITEMS = 1375;

  typedef struct {
    logic [dmac_pkg::CMD_W-1:0]   command;
    logic [dmac_pkg::IDX_W-1:0]   slot_index;
    logic [dmac_pkg::FIELD_W-1:0] entry_handle;
    logic                         handle_is_null;
  } cache_cmd_t;

  typedef struct {
    logic                         hit;
    logic                         marker_hit;
    logic [dmac_pkg::FIELD_W-1:0] found_handle;
    logic [dmac_pkg::COUNT_W-1:0] live_count;
  } lookup_rsp_t;

  logic                         clk            = 1'b0;
  logic                         rst            = 1'b1;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic [dmac_pkg::CMD_W-1:0]   command        = dmac_pkg::CMD_FIND;
  logic [dmac_pkg::IDX_W-1:0]   slot_index     = '0;
  logic [dmac_pkg::FIELD_W-1:0] entry_handle   = '0;
  logic                         handle_is_null = 1'b0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic                         hit;
  logic                         marker_hit;
  logic [dmac_pkg::FIELD_W-1:0] found_handle;
  logic [dmac_pkg::COUNT_W-1:0] live_count;

  // Shadow copy of the slot table.
  logic [1:0]                   shadow_kind   [SLOTS];
  logic [dmac_pkg::FIELD_W-1:0] shadow_handle [SLOTS];
  logic                         shadow_refd   [SLOTS];
  int unsigned                  shadow_live;

  cache_cmd_t  commands_pending [$];
  lookup_rsp_t lookups_due      [$];
  cache_cmd_t  cmd_on_bus;
  lookup_rsp_t want;
  int          total_items  = 0;
  int          sent_count   = 0;
  int          results_seen = 0;
  int          errors       = 0;
  logic        sender_gap;

  direct_mapped_aging_cache_unit #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .slot_index     (slot_index),
    .entry_handle   (entry_handle),
    .handle_is_null (handle_is_null),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .marker_hit     (marker_hit),
    .found_handle   (found_handle),
    .live_count     (live_count)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow table and return the answer it must give.
  function automatic lookup_rsp_t cache_update(cache_cmd_t c);
    lookup_rsp_t r;
    logic        in_range;
    int unsigned i;
    r.hit          = 1'b0;
    r.marker_hit   = 1'b0;
    r.found_handle = '0;
    in_range = c.slot_index < SLOTS;
    i = in_range ? c.slot_index : 0;
    case (c.command)
      dmac_pkg::CMD_ADD: begin
        if (in_range) begin
          // Overwrite whatever was there; a live entry leaves the count.
          if (shadow_kind[i] == dmac_pkg::KIND_LIVE) shadow_live--;
          if (c.handle_is_null) begin
            shadow_kind[i] = dmac_pkg::KIND_MARKER;
          end else begin
            shadow_kind[i]   = dmac_pkg::KIND_LIVE;
            shadow_handle[i] = c.entry_handle & HANDLE_MASK;
            shadow_live++;
          end
          shadow_refd[i] = 1'b0;
        end
      end
      dmac_pkg::CMD_REMOVE: begin
        if (in_range) begin
          if (shadow_kind[i] == dmac_pkg::KIND_LIVE) shadow_live--;
          shadow_kind[i] = dmac_pkg::KIND_EMPTY;
          shadow_refd[i] = 1'b0;
        end
      end
      dmac_pkg::CMD_CLEAR: begin
        for (int k = 0; k < SLOTS; k++) begin
          shadow_kind[k] = dmac_pkg::KIND_EMPTY;
          shadow_refd[k] = 1'b0;
        end
        shadow_live = 0;
      end
      dmac_pkg::CMD_FIND: begin
        if (in_range) begin
          if (shadow_kind[i] == dmac_pkg::KIND_MARKER) begin
            r.hit        = 1'b1;
            r.marker_hit = 1'b1;
          end else if (shadow_kind[i] == dmac_pkg::KIND_LIVE) begin
            r.hit          = 1'b1;
            r.found_handle = shadow_handle[i];
            shadow_refd[i] = 1'b1;
          end
        end
      end
      dmac_pkg::CMD_SWEEP: begin
        // Second chance: strip the referenced bit, or evict when already stripped.
        for (int k = 0; k < SLOTS; k++) begin
          if (shadow_kind[k] == dmac_pkg::KIND_LIVE) begin
            if (shadow_refd[k]) begin
              shadow_refd[k] = 1'b0;
            end else begin
              shadow_kind[k] = dmac_pkg::KIND_EMPTY;
              shadow_live--;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.live_count = (shadow_live > dmac_pkg::LIVE_MAX) ?
                   dmac_pkg::COUNT_W'(dmac_pkg::LIVE_MAX) :
                   dmac_pkg::COUNT_W'(shadow_live);
    return r;
  endfunction

  task automatic queue_cmd(logic [dmac_pkg::CMD_W-1:0] cmd,
                           logic [dmac_pkg::IDX_W-1:0] idx,
                           logic [dmac_pkg::FIELD_W-1:0] handle, logic is_null);
    cache_cmd_t c;
    c.command        = cmd;
    c.slot_index     = idx;
    c.entry_handle   = handle;
    c.handle_is_null = is_null;
    commands_pending.insert(commands_pending.size(), c);
  endtask

  // Driver: present the next pending transaction, hold it until accepted, and
  // predict its answer at the edge of acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        lookups_due.insert(lookups_due.size(), cache_update(cmd_on_bus));
        sent_count++;
      end
      sender_gap = !(sent_count >= QUIET_FROM && sent_count < QUIET_TO) &&
                   ($urandom_range(99) < 22);
      if (in_valid && !in_ready) begin
        // Hold valid and payload until the block takes them.
      end else if (commands_pending.size() != 0 && !sender_gap) begin
        cmd_on_bus = commands_pending.pop_front();
        in_valid       <= 1'b1;
        command        <= cmd_on_bus.command;
        slot_index     <= cmd_on_bus.slot_index;
        entry_handle   <= cmd_on_bus.entry_handle;
        handle_is_null <= cmd_on_bus.handle_is_null;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check every accepted answer against the oldest prediction, then
  // stall the output side at random outside the quiet window.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lookups_due.size() == 0) begin
          $display("%0t: unexpected result: hit %0d marker %0d handle %h count %0d",
                   $time, hit, marker_hit, found_handle, live_count);
          errors++;
        end else begin
          want = lookups_due.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0d, actual %0d", $time, want.hit, hit);
            errors++;
          end
          if (marker_hit !== want.marker_hit) begin
            $display("%0t: marker_hit mismatch: expected %0d, actual %0d",
                     $time, want.marker_hit, marker_hit);
            errors++;
          end
          if (found_handle !== want.found_handle) begin
            $display("%0t: found_handle mismatch: expected %h, actual %h",
                     $time, want.found_handle, found_handle);
            errors++;
          end
          if (live_count !== want.live_count) begin
            $display("%0t: live_count mismatch: expected %0d, actual %0d",
                     $time, want.live_count, live_count);
            errors++;
          end
        end
        results_seen++;
      end
      out_ready <= (results_seen >= QUIET_FROM && results_seen < QUIET_TO) ||
                   ($urandom_range(99) >= 22);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int pick;
    int walks_left;
    logic [dmac_pkg::CMD_W-1:0] cmd;
    logic [dmac_pkg::IDX_W-1:0] idx;
    for (int k = 0; k < SLOTS; k++) begin
      shadow_kind[k]   = dmac_pkg::KIND_EMPTY;
      shadow_handle[k] = '0;
      shadow_refd[k]   = 1'b0;
    end
    shadow_live = 0;

    // Directed: empty miss, extremes of index and handle, marker slots,
    // out-of-range indices, both outcomes of a sweep, overwrites, unknown
    // commands and clear all.
    queue_cmd(dmac_pkg::CMD_FIND,   16'd0,    16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_ADD,    16'd0,    16'hFFFF, 1'b0);
    queue_cmd(dmac_pkg::CMD_FIND,   16'd0,    16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_ADD,    TOP_SLOT, 16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_ADD,    OUT_SLOT, 16'h1234, 1'b0);
    queue_cmd(dmac_pkg::CMD_FIND,   OUT_SLOT, 16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_ADD,    16'd5,    16'hFFFF, 1'b1);
    queue_cmd(dmac_pkg::CMD_FIND,   16'd5,    16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_ADD,    16'hFFFF, 16'hBEEF, 1'b1);
    queue_cmd(dmac_pkg::CMD_FIND,   16'hFFFF, 16'hFFFF, 1'b1);
    queue_cmd(dmac_pkg::CMD_FIND,   TOP_SLOT, 16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_ADD,    16'd7,    16'hA5A5, 1'b0);
    queue_cmd(dmac_pkg::CMD_SWEEP,  16'd0,    16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_FIND,   16'd7,    16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_FIND,   16'd0,    16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_SWEEP,  16'hFFFF, 16'hFFFF, 1'b1);
    queue_cmd(dmac_pkg::CMD_REMOVE, OUT_SLOT, 16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_REMOVE, 16'd0,    16'h0000, 1'b0);
    queue_cmd(CMD_RSVD_LO,          16'd5,    16'h5A5A, 1'b1);
    queue_cmd(CMD_RSVD_MID,         16'hFFFF, 16'hFFFF, 1'b0);
    queue_cmd(CMD_RSVD_HI,          16'd0,    16'h0000, 1'b1);
    queue_cmd(dmac_pkg::CMD_ADD,    16'd5,    16'h5A5A, 1'b0);
    queue_cmd(dmac_pkg::CMD_ADD,    16'd5,    16'h0000, 1'b1);
    queue_cmd(dmac_pkg::CMD_CLEAR,  16'd0,    16'h0000, 1'b0);
    queue_cmd(dmac_pkg::CMD_FIND,   16'd5,    16'h0000, 1'b0);

    // Random: mostly a small hot set of slots so finds hit, with the whole
    // table, the upper boundary and the full index range mixed in.
    walks_left = WALK_BUDGET;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 34)      cmd = dmac_pkg::CMD_ADD;
      else if (pick < 46) cmd = dmac_pkg::CMD_REMOVE;
      else if (pick < 82) cmd = dmac_pkg::CMD_FIND;
      else if (pick < 87) cmd = dmac_pkg::CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
      else if (pick < 93) cmd = dmac_pkg::CMD_SWEEP;
      else if (pick < 95) cmd = dmac_pkg::CMD_CLEAR;
      else                cmd = dmac_pkg::CMD_ADD;
      if (cmd == dmac_pkg::CMD_SWEEP || cmd == dmac_pkg::CMD_CLEAR) begin
        if (walks_left == 0) cmd = dmac_pkg::CMD_FIND;
        else walks_left--;
      end
      pick = $urandom_range(99);
      if (pick < 55)      idx = dmac_pkg::IDX_W'($urandom_range(15));
      else if (pick < 75) idx = dmac_pkg::IDX_W'($urandom_range(SLOTS - 1));
      else if (pick < 88) idx = dmac_pkg::IDX_W'($urandom_range(SLOTS + 3, SLOTS - 4));
      else                idx = dmac_pkg::IDX_W'($urandom_range(16'hFFFF));
      queue_cmd(cmd, idx, dmac_pkg::FIELD_W'($urandom_range(16'hFFFF)),
                $urandom_range(3) == 0);
    end
    total_items = commands_pending.size();

    // Release reset; the block then runs its clearing pass with in_ready low.
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: every transaction sent and every answer back, then idle a while
    // longer to catch stray results.
    do @(negedge clk); while (sent_count != total_items || lookups_due.size() != 0);
    repeat (SLOTS + 8) @(negedge clk);
    if (errors == 0) begin
      $display("direct_mapped_aging_cache_unit test passed");
    end else begin
      $display("direct_mapped_aging_cache_unit test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("direct_mapped_aging_cache_unit test failed");
    $finish;
  end

endmodule
